[design/assert_macros.svh]
// Assertion macros used by the column p-norm sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CLP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("column p-norm assertion failed");

// When cond holds at one edge, nxt must hold at the following edge.
`define CLP_ASSERT_NEXT(name, clk, rst_n, cond, nxt) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("column p-norm sequencing assertion failed");

`endif

[design/clp_pkg.sv]
// Shared types and constants of the column p-norm block.
package clp_pkg;

  localparam int MAX_COLUMNS_DEF = 8;

  localparam int ORDER_W = 4;
  localparam int CFG_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int SAMPLE_W = 32;
  localparam int NORM_W  = 32;
  localparam int ACC_W   = 64;
  localparam int MAG_W   = 33;
  localparam int STEP_W  = 6;
  localparam int CIDX_W  = 3;

  localparam logic [ORDER_W-1:0] MAX_ORDER = 4'd8;
  localparam logic [ORDER_W-1:0] ORDER_LINF = 4'd0;
  localparam logic [ORDER_W-1:0] ORDER_L1 = 4'd1;
  localparam logic [ORDER_W-1:0] ORDER_L2 = 4'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NORM_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_BY_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_IN_USE = 2'd2;

  localparam logic [CFG_W-1:0] RESET_ORDER = 4'd2;
  localparam logic RESET_SCALE = 1'b1;
  localparam logic [CFG_W-1:0] RESET_COLUMNS = 4'd1;

  // Last step index of each iterative unit.
  localparam logic [STEP_W-1:0] SQRT_LAST = 6'd31;
  localparam logic [STEP_W-1:0] ROOT_LAST = 6'd32;
  localparam logic [STEP_W-1:0] DIV_LAST  = 6'd63;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_ELEM,
    DP_MUL1,
    DP_MUL2,
    DP_MUL3,
    DP_ACC_MAX,
    DP_ACC_ADD_MAG,
    DP_ACC_ADD_Y,
    DP_FIN_START,
    DP_COL_LOAD,
    DP_SQRT_STEP,
    DP_ROOT_TRY,
    DP_ROOT_CMP,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_OUT,
    DP_OUT_EMPTY,
    DP_NEXT_COL,
    DP_CLEAR
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   raw;
  } dp_cmd_t;

  typedef struct packed {
    logic rows_zero;
    logic out_last;
  } dp_sts_t;

endpackage

[design/clp_datapath.sv]
// Datapath of the column p-norm block: accumulators, multiplier, root and divide units.
module clp_datapath import clp_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int CNTW = $clog2(MAX_COLUMNS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic [CNTW-1:0]     cols_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic [CIDX_W-1:0]   column_index_o,
  output logic [NORM_W-1:0]   norm_value_o,
  output logic                last_result_o,
  output logic                empty_error_o
);

  localparam int IDXW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int FULLW = ACC_W + MAG_W + 1;

  logic [ACC_W-1:0]  acc_q [MAX_COLUMNS];
  logic [CNTW-1:0]   pos_q, fcol_q;
  logic [31:0]       rows_q;
  logic [IDXW-1:0]   cur_q;
  logic [MAG_W-1:0]  mb_q, r_q, rbit_q;
  logic [ACC_W-1:0]  y_q, p0_q, p1_q, val_q, aval_q;
  logic [ACC_W-1:0]  srem_q, sroot_q, sbit_q;
  logic [31:0]       drem_q;
  logic [CIDX_W-1:0] oidx_q;
  logic [NORM_W-1:0] onorm_q;
  logic              olast_q, oerr_q;

  logic [IDXW-1:0]   rd_idx;
  logic [ACC_W-1:0]  acc_rd;
  logic [CNTW-1:0]   pos_eff, pos_inc;
  logic [MAG_W-1:0]  mag;
  logic [31:0]       mul_a;
  logic [ACC_W-1:0]  prod;
  logic [FULLW-1:0]  full;
  logic [ACC_W:0]    add_sum;
  logic [ACC_W-1:0]  addend;
  logic [ACC_W-1:0]  sq_try, sroot_n;
  logic              sq_ge;
  logic [MAG_W-1:0]  r_n;
  logic [32:0]       div_sh, div_sub;
  logic              div_ge;
  logic [CNTW:0]     fcol_inc;
  logic [CNTW+2:0]   fcol_wide;

  assign rd_idx = (cmd_i.op == DP_COL_LOAD) ? fcol_q[IDXW-1:0] : cur_q;
  assign acc_rd = acc_q[rd_idx];

  assign pos_eff = (pos_q >= cols_i) ? '0 : pos_q;
  assign pos_inc = pos_eff + 1'b1;
  assign mag = sample_i[SAMPLE_W-1] ? (33'h1_0000_0000 - {1'b0, sample_i}) : {1'b0, sample_i};

  // One 32x32 multiplier serves both partial products of the Q16.16 product.
  assign mul_a = (cmd_i.op == DP_MUL2) ? y_q[63:32] : y_q[31:0];
  assign prod  = mul_a * mb_q[31:0];
  assign full  = {34'd0, p0_q} + {2'd0, p1_q, 32'd0}
               + (mb_q[32] ? {2'd0, y_q, 32'd0} : {FULLW{1'b0}});

  assign addend  = (cmd_i.op == DP_ACC_ADD_MAG) ? {31'd0, mb_q} : y_q;
  assign add_sum = {1'b0, acc_rd} + {1'b0, addend};

  assign sq_try  = sroot_q | sbit_q;
  assign sq_ge   = srem_q >= sq_try;
  assign sroot_n = sq_ge ? ((sroot_q >> 1) | sbit_q) : (sroot_q >> 1);

  assign r_n = (y_q <= aval_q) ? mb_q : r_q;

  assign div_sh  = {drem_q, val_q[63]};
  assign div_ge  = div_sh >= {1'b0, rows_q};
  assign div_sub = div_sh - {1'b0, rows_q};

  assign fcol_inc  = {1'b0, fcol_q} + 1'b1;
  assign fcol_wide = {3'd0, fcol_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_COLUMNS; i++) begin
        acc_q[i] <= '0;
      end
      pos_q  <= '0;
      rows_q <= '0;
      fcol_q <= '0;
    end else begin
      case (cmd_i.op)
        DP_ELEM: begin
          if (pos_eff == '0 && rows_q != 32'hFFFF_FFFF) begin
            rows_q <= rows_q + 32'd1;
          end
          pos_q <= (pos_inc >= cols_i) ? '0 : pos_inc;
        end
        DP_ACC_MAX: begin
          if ({31'd0, mb_q} > acc_rd) begin
            acc_q[cur_q] <= {31'd0, mb_q};
          end
        end
        DP_ACC_ADD_MAG, DP_ACC_ADD_Y: begin
          acc_q[cur_q] <= add_sum[ACC_W] ? {ACC_W{1'b1}} : add_sum[ACC_W-1:0];
        end
        DP_FIN_START: fcol_q <= '0;
        DP_NEXT_COL:  fcol_q <= fcol_inc[CNTW-1:0];
        DP_CLEAR: begin
          for (int i = 0; i < MAX_COLUMNS; i++) begin
            acc_q[i] <= '0;
          end
          pos_q  <= '0;
          rows_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_ELEM: begin
        cur_q <= pos_eff[IDXW-1:0];
        mb_q  <= mag;
        y_q   <= {31'd0, mag};
      end
      DP_MUL1: p0_q <= prod;
      DP_MUL2: p1_q <= prod;
      DP_MUL3: begin
        if (cmd_i.raw) begin
          y_q <= full[ACC_W-1:0];
        end else begin
          y_q <= (|full[FULLW-1:80]) ? {ACC_W{1'b1}} : full[79:16];
        end
      end
      DP_COL_LOAD: begin
        aval_q  <= acc_rd;
        val_q   <= acc_rd;
        srem_q  <= acc_rd;
        sroot_q <= '0;
        sbit_q  <= 64'h4000_0000_0000_0000;
        r_q     <= '0;
        rbit_q  <= 33'h1_0000_0000;
      end
      DP_SQRT_STEP: begin
        if (sq_ge) begin
          srem_q <= srem_q - sq_try;
        end
        sroot_q <= sroot_n;
        sbit_q  <= sbit_q >> 2;
        val_q   <= sroot_n;
      end
      DP_ROOT_TRY: begin
        mb_q <= r_q | rbit_q;
        y_q  <= {31'd0, r_q | rbit_q};
      end
      DP_ROOT_CMP: begin
        r_q    <= r_n;
        rbit_q <= rbit_q >> 1;
        val_q  <= {31'd0, r_n};
      end
      DP_DIV_INIT: drem_q <= '0;
      DP_DIV_STEP: begin
        drem_q <= div_ge ? div_sub[31:0] : div_sh[31:0];
        val_q  <= {val_q[62:0], div_ge};
      end
      DP_OUT: begin
        oidx_q  <= fcol_wide[CIDX_W-1:0];
        onorm_q <= (|val_q[63:32]) ? {NORM_W{1'b1}} : val_q[31:0];
        olast_q <= (fcol_inc == {1'b0, cols_i});
        oerr_q  <= 1'b0;
      end
      DP_OUT_EMPTY: begin
        oidx_q  <= '0;
        onorm_q <= '0;
        olast_q <= 1'b1;
        oerr_q  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.rows_zero = (rows_q == '0);
  assign sts_o.out_last  = olast_q;

  assign column_index_o = oidx_q;
  assign norm_value_o   = onorm_q;
  assign last_result_o  = olast_q;
  assign empty_error_o  = oerr_q;

endmodule

[design/clp_ctrl.sv]
// Sequencer of the column p-norm block: steps the datapath through each item.
module clp_ctrl import clp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               command_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [ORDER_W-1:0] order_i,
  input  logic               scale_i,
  input  dp_sts_t            sts_i,
  output dp_cmd_t            cmd_o
);

`include "assert_macros.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_MUL2  = 4'd2;
  localparam logic [3:0] S_MUL3  = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_FIN   = 4'd5;
  localparam logic [3:0] S_LOAD  = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_TRY   = 4'd8;
  localparam logic [3:0] S_CMP   = 4'd9;
  localparam logic [3:0] S_DIVI  = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;
  localparam logic [3:0] S_CLEAR = 4'd14;

  logic [3:0]         state_q, state_d;
  logic [ORDER_W-1:0] k_q, k_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               ctx_q, ctx_d;
  logic               scale_go;
  logic [3:0]         after_root;
  logic [ORDER_W:0]   k_inc;

  assign scale_go   = scale_i && (order_i != ORDER_LINF);
  assign after_root = scale_go ? S_DIVI : S_OUT;
  assign k_inc      = {1'b0, k_q} + 1'b1;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    step_d     = step_q;
    ctx_d      = ctx_q;
    cmd_o.op   = DP_NOP;
    cmd_o.raw  = (order_i == ORDER_L2);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (command_i) begin
            cmd_o.op = DP_FIN_START;
            state_d  = S_FIN;
          end else begin
            cmd_o.op = DP_ELEM;
            k_d      = 4'd1;
            ctx_d    = 1'b0;
            if (order_i == ORDER_LINF || order_i == ORDER_L1) begin
              state_d = S_ACC;
            end else begin
              state_d = S_MUL1;
            end
          end
        end
      end
      S_MUL1: begin
        cmd_o.op = DP_MUL1;
        state_d  = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.op = DP_MUL2;
        state_d  = S_MUL3;
      end
      S_MUL3: begin
        cmd_o.op = DP_MUL3;
        k_d      = k_inc[ORDER_W-1:0];
        if (k_inc < {1'b0, order_i}) begin
          state_d = S_MUL1;
        end else begin
          state_d = ctx_q ? S_CMP : S_ACC;
        end
      end
      S_ACC: begin
        if (order_i == ORDER_LINF) begin
          cmd_o.op = DP_ACC_MAX;
        end else if (order_i == ORDER_L1) begin
          cmd_o.op = DP_ACC_ADD_MAG;
        end else begin
          cmd_o.op = DP_ACC_ADD_Y;
        end
        state_d = S_IDLE;
      end
      S_FIN: begin
        if (sts_i.rows_zero) begin
          cmd_o.op = DP_OUT_EMPTY;
          state_d  = S_EMIT;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.op = DP_COL_LOAD;
        step_d   = '0;
        if (order_i == ORDER_LINF || order_i == ORDER_L1) begin
          state_d = after_root;
        end else if (order_i == ORDER_L2) begin
          state_d = S_SQRT;
        end else begin
          state_d = S_TRY;
        end
      end
      S_SQRT: begin
        cmd_o.op = DP_SQRT_STEP;
        step_d   = step_q + 1'b1;
        if (step_q == SQRT_LAST) begin
          state_d = after_root;
        end
      end
      S_TRY: begin
        cmd_o.op = DP_ROOT_TRY;
        k_d      = 4'd1;
        ctx_d    = 1'b1;
        state_d  = S_MUL1;
      end
      S_CMP: begin
        cmd_o.op = DP_ROOT_CMP;
        step_d   = step_q + 1'b1;
        state_d  = (step_q == ROOT_LAST) ? after_root : S_TRY;
      end
      S_DIVI: begin
        cmd_o.op = DP_DIV_INIT;
        step_d   = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = DP_DIV_STEP;
        step_d   = step_q + 1'b1;
        if (step_q == DIV_LAST) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        cmd_o.op = DP_OUT;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall_i) begin
          if (sts_i.out_last) begin
            state_d = S_CLEAR;
          end else begin
            cmd_o.op = DP_NEXT_COL;
            state_d  = S_LOAD;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      step_q  <= '0;
      ctx_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      step_q  <= step_d;
      ctx_q   <= ctx_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);

  `CLP_ASSERT(a_result_blocks_input, clk_i, rst_ni, !out_valid_o || in_stall_o)
  `CLP_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q != S_IDLE)
  `CLP_ASSERT(a_sqrt_step_bound, clk_i, rst_ni, state_q != S_SQRT || step_q <= SQRT_LAST)

endmodule

[design/column_lp_norm.sv]
// Top level of the column p-norm block: configuration registers, sequencer and datapath.
// Usage: table elements arrive on the input channel in row-major order, one signed Q16.16
// sample per item with command 0; an item with command 1 finishes the table. Both channels
// use valid and stall: an item moves on a clock edge with valid high and stall low.
// The block takes one item at a time and stalls its input until it is through with it.
// A max-abs or L1 data item goes from the element step to one accumulate step; for order
// p >= 2 it first passes p-1 times through the shared 32x32 multiplier, which forms each
// Q16.16 product in the states MUL1, MUL2 and MUL3. A finish checks the row count, then
// emits one result per column: each column is loaded, takes a bit-serial square root for
// order 2 or 33 trials of the p-th root for order p >= 3, then bit-serial division by the
// row count when scaling is on and the order is not max-abs, and its result is registered
// and presented. A finish with no rows registers its error result during the row check.
// After the last result the state is cleared. While a result waits under stall the block
// holds it and takes no new item. Reset clears the accumulators, the row and column
// counters and sets order 2, scaling on, one column. The user must write configuration
// through a plain write port only while the block is idle; the block does not enforce it.
module column_lp_norm import clp_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [SAMPLE_W-1:0]  sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CIDX_W-1:0]    column_index_o,
  output logic [NORM_W-1:0]    norm_value_o,
  output logic                 last_result_o,
  output logic                 empty_error_o
);

  localparam int CNTW = $clog2(MAX_COLUMNS + 1);
  localparam int CMPW = (CNTW > CFG_W) ? CNTW : CFG_W;

  logic [CFG_W-1:0] norm_order_q, norm_order_d;
  logic             scale_q, scale_d;
  logic [CFG_W-1:0] columns_q, columns_d;

  logic [ORDER_W-1:0] order_eff;
  logic [CMPW-1:0]    cols_cfg, cols_max, cols_eff;
  dp_cmd_t            cmd;
  dp_sts_t            sts;

  // Register writes; an index past the list is ignored.
  always_comb begin
    norm_order_d = norm_order_q;
    scale_d      = scale_q;
    columns_d    = columns_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NORM_ORDER:     norm_order_d = cfg_data_i;
        CFG_SCALE_BY_ROWS:  scale_d      = cfg_data_i[0];
        CFG_COLUMNS_IN_USE: columns_d    = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_order_q <= RESET_ORDER;
      scale_q      <= RESET_SCALE;
      columns_q    <= RESET_COLUMNS;
    end else begin
      norm_order_q <= norm_order_d;
      scale_q      <= scale_d;
      columns_q    <= columns_d;
    end
  end

  // Orders above the supported maximum saturate; a column count of zero acts as one,
  // and counts above the storage act as the full storage.
  assign order_eff = (norm_order_q > MAX_ORDER) ? MAX_ORDER : norm_order_q;
  assign cols_cfg  = CMPW'(columns_q);
  assign cols_max  = CMPW'(MAX_COLUMNS);
  assign cols_eff  = (cols_cfg == '0) ? CMPW'(1) :
                     (cols_cfg > cols_max) ? cols_max : cols_cfg;

  clp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .order_i     (order_eff),
    .scale_i     (scale_q),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  clp_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .CNTW        (CNTW)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cols_i         (cols_eff[CNTW-1:0]),
    .sample_i       (sample_i),
    .column_index_o (column_index_o),
    .norm_value_o   (norm_value_o),
    .last_result_o  (last_result_o),
    .empty_error_o  (empty_error_o)
  );

endmodule

[bench/column_lp_norm_test.sv]
// Testbench of the column p-norm block with a scoreboard that predicts every norm.
`timescale 1ns / 100ps

module column_lp_norm_test;
  import clp_pkg::*;

  typedef struct {
    logic [CIDX_W-1:0] column;
    logic [NORM_W-1:0] norm;
    logic              last;
    logic              empty;
  } norm_result_t;

  // Predicts the norms of the block and holds those still to arrive.
  class norm_scoreboard;
    logic [63:0]        acc [8];
    int unsigned        col_pos;
    int unsigned        rows;
    logic [3:0]         order;
    logic               scale;
    logic [3:0]         columns;
    norm_result_t       awaited [$];
    int                 fails;

    function void clear_table();
      foreach (acc[i]) acc[i] = '0;
      col_pos = 0;
      rows = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_NORM_ORDER) order = val;
      else if (idx == CFG_SCALE_BY_ROWS) scale = val[0];
      else if (idx == CFG_COLUMNS_IN_USE) columns = val;
    endfunction

    function void init();
      clear_table();
      order = RESET_ORDER;
      scale = RESET_SCALE;
      columns = RESET_COLUMNS;
      fails = 0;
      awaited.delete();
    endfunction

    // Q16.16 product, truncated and saturated at 64 bits.
    function logic [63:0] mul_fix(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'b0, a} * {64'b0, b};
      if (|p[127:80]) return '1;
      return p[79:16];
    endfunction

    function logic [63:0] power_fix(logic [63:0] a, int unsigned p);
      logic [63:0] y;
      y = a;
      for (int unsigned k = 1; k < p; k++) y = mul_fix(y, a);
      return y;
    endfunction

    function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    function logic [63:0] square_root(logic [63:0] v);
      logic [63:0] r, c;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    function logic [63:0] pth_root(logic [63:0] v, int unsigned p);
      logic [63:0] r, c;
      r = '0;
      for (int b = 32; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (power_fix(c, p) <= v) r = c;
      end
      return r;
    endfunction

    // Called for every accepted input item.
    function void note_input(logic cmd, logic [31:0] smp);
      int unsigned  p, cols;
      logic [63:0]  mag, v;
      norm_result_t r;
      p = (order > MAX_ORDER) ? MAX_ORDER : order;
      cols = (columns == 0) ? 1 : ((columns > 8) ? 8 : columns);
      if (!cmd) begin
        mag = smp[31] ? (64'h1_0000_0000 - {32'b0, smp}) : {32'b0, smp};
        if (col_pos >= cols) col_pos = 0;
        if (col_pos == 0 && rows != 32'hFFFF_FFFF) rows++;
        if (p == 0) begin
          if (mag > acc[col_pos]) acc[col_pos] = mag;
        end else if (p == 1) acc[col_pos] = add_sat(acc[col_pos], mag);
        else if (p == 2) acc[col_pos] = add_sat(acc[col_pos], mag * mag);
        else acc[col_pos] = add_sat(acc[col_pos], power_fix(mag, p));
        col_pos++;
        if (col_pos >= cols) col_pos = 0;
        return;
      end
      if (rows == 0) begin
        r = '{column: '0, norm: '0, last: 1'b1, empty: 1'b1};
        awaited.push_back(r);
      end else begin
        for (int unsigned i = 0; i < cols; i++) begin
          if (p <= 1) v = acc[i];
          else if (p == 2) v = square_root(acc[i]);
          else v = pth_root(acc[i], p);
          if (scale && p != 0) v = v / rows;
          if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
          r = '{column: i[2:0], norm: v[31:0], last: (i + 1 == cols), empty: 1'b0};
          awaited.push_back(r);
        end
      end
      clear_table();
    endfunction

    // Called for every accepted result item.
    function void check_result(norm_result_t got);
      norm_result_t exp_r;
      if (awaited.size() == 0) begin
        $error("result item with no norm awaited: column %0d", got.column);
        fails++;
        return;
      end
      exp_r = awaited.pop_front();
      if (got.column !== exp_r.column) begin
        $error("column_index: expected %0d, got %0d", exp_r.column, got.column);
        fails++;
      end
      if (got.norm !== exp_r.norm) begin
        $error("norm_value: expected %h, got %h", exp_r.norm, got.norm);
        fails++;
      end
      if (got.last !== exp_r.last) begin
        $error("last_result: expected %b, got %b", exp_r.last, got.last);
        fails++;
      end
      if (got.empty !== exp_r.empty) begin
        $error("empty_error: expected %b, got %b", exp_r.empty, got.empty);
        fails++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 command_i = 1'b0;
  logic [SAMPLE_W-1:0]  sample_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [CIDX_W-1:0]    column_index_o;
  logic [NORM_W-1:0]    norm_value_o;
  logic                 last_result_o;
  logic                 empty_error_o;

  // Idle rates in percent for the sending and the receiving side.
  int unsigned    tx_idle_pct = 0;
  int unsigned    rx_idle_pct = 0;
  norm_scoreboard norms = new();

  column_lp_norm u_top (.*);

  always #5 clk_i = ~clk_i;

  // Receiving side: checks every accepted result and stalls at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        norms.check_result('{column: column_index_o, norm: norm_value_o,
                             last: last_result_o, empty: empty_error_o});
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Sends one item and returns at the edge where it is accepted. A gap, when one
  // is drawn, lowers valid first, so valid never falls and rises in one step.
  task automatic send_item(logic cmd, logic [31:0] smp);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    sample_i   <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    norms.note_input(cmd, smp);
  endtask

  // Stops sending until every awaited norm has come, then lets the block
  // finish any data item still in its multiplier.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (norms.awaited.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Register writes happen only after a drain, while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    norms.set_reg(idx, val);
  endtask

  task automatic setup(logic [3:0] ord, logic scl, logic [3:0] cols);
    drain();
    write_reg(CFG_NORM_ORDER, ord);
    write_reg(CFG_SCALE_BY_ROWS, {3'b0, scl});
    write_reg(CFG_COLUMNS_IN_USE, cols);
  endtask

  // Mixes full-range samples with small ones, so high orders do not always
  // saturate, and with the extremes of the field.
  function automatic logic [31:0] pick_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h0003_0000) - 32'h0001_8000;
      2: return $urandom_range(32'h0000_3000) - 32'h0000_1800;
      default: return ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  initial begin
    #10ms;
    $display("column_lp_norm test failed");
    $finish;
  end

  initial begin
    int unsigned sent, n_rows, cols;
    norms.init();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. An empty table under the reset settings gives the error result.
    send_item(1'b1, '0);
    // Max-abs norm with the sample extremes and a partial last row.
    setup(ORDER_LINF, 1'b0, 4'd3);
    send_item(1'b0, 32'h7FFF_FFFF);
    send_item(1'b0, 32'h8000_0000);
    send_item(1'b0, 32'h0000_0000);
    send_item(1'b0, 32'hFFFF_FFFF);
    send_item(1'b0, 32'h0000_0001);
    send_item(1'b1, '0);
    // L1 with scaling.
    setup(ORDER_L1, 1'b1, 4'd2);
    send_item(1'b0, 32'h0001_0000);
    send_item(1'b0, 32'hFFFE_0000);
    send_item(1'b0, 32'h0003_0000);
    send_item(1'b1, '0);
    // L2 with the most negative sample until the sum saturates.
    setup(ORDER_L2, 1'b0, 4'd1);
    repeat (5) send_item(1'b0, 32'h8000_0000);
    send_item(1'b1, '0);
    // An order beyond the maximum acts as the maximum; zero columns act as one.
    setup(4'd15, 1'b1, 4'd0);
    send_item(1'b0, 32'h0002_0000);
    send_item(1'b0, 32'hFFFF_0000);
    send_item(1'b1, '0);
    // Too many columns act as the maximum; a change of settings mid-table moves
    // the position past the new column count, so the next element starts a row.
    setup(4'd3, 1'b0, 4'd12);
    send_item(1'b0, 32'h0001_8000);
    send_item(1'b1, '0);
    setup(4'd3, 1'b1, 4'd4);
    repeat (3) send_item(1'b0, pick_sample());
    setup(ORDER_L1, 1'b1, 4'd2);
    send_item(1'b0, 32'h0004_0000);
    send_item(1'b1, '0);

    // Random part in three idling phases.
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 9 : ((ph == 1) ? 87 : 0);
      rx_idle_pct = (ph == 0) ? 87 : ((ph == 1) ? 9 : 0);
      sent = 0;
      while (sent < 62) begin
        setup(4'($urandom_range(15)), 1'($urandom_range(1)), 4'($urandom_range(15)));
        if ($urandom_range(9) == 0) begin
          send_item(1'b1, $urandom);
          sent++;
          continue;
        end
        cols = (norms.columns == 0) ? 1 : ((norms.columns > 8) ? 8 : norms.columns);
        n_rows = $urandom_range(1, 3);
        repeat (n_rows * cols - $urandom_range(cols - 1)) begin
          send_item(1'b0, pick_sample());
          sent++;
        end
        send_item(1'b1, $urandom);
        sent++;
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (norms.fails == 0 && norms.awaited.size() == 0) begin
      $display("column_lp_norm test passed");
    end else begin
      $display("column_lp_norm test failed");
    end
    $finish;
  end

endmodule
